/* hdl/ffha_pkg.sv */
// Shared types and constants for the first-fit heap allocator.
package ffha_pkg;

  localparam int MaxSegments = 64;
  localparam int HeaderBytes = 24;
  localparam int SlotW = $clog2(MaxSegments);
  localparam int LinkW = SlotW + 1;
  localparam int CountW = 7;
  localparam int OffW = 24;
  localparam int AddrW = 32;
  localparam logic [LinkW-1:0] NoLink = LinkW'(MaxSegments);

  localparam logic [0:0] CfgRegionBase = 1'b0;
  localparam logic [0:0] CfgRegionSize = 1'b1;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StNoSpace  = 2'd1,
    StNotFound = 2'd2,
    StBadReq   = 2'd3
  } status_t;

  // One list entry as held in the segment table.
  typedef struct packed {
    logic [OffW-1:0]  start;
    logic [OffW-1:0]  size;
    logic             free;
    logic [LinkW-1:0] link;
  } seg_t;

  localparam int SegW = $bits(seg_t);

  // Controller to datapath commands.
  typedef struct packed {
    logic load;      // capture request, start at head
    logic rd;        // issue read of current slot
    logic rd_next;   // issue read of successor slot
    logic do_alloc;  // apply allocate on current slot
    logic do_merge;  // merge successor into current
    logic do_mark;   // mark current free
    logic advance;   // follow current link
    logic finish;    // latch result with status
    status_t status;
  } ctl_t;

  // Datapath to controller status.
  typedef struct packed {
    logic bad;
    logic is_free_req;
    logic cur_none;
    logic out_of_steps;
    logic fits;       // allocate hits current segment
    logic addr_hit;   // free address matches current
    logic next_free;  // successor exists and is free
    logic init_busy;
  } sts_t;

endpackage

/* hdl/ffha_if.sv */
// Valid/ready channel carrying one payload.
interface ffha_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hdl/ffha_ram.sv */
// Generic single-port RAM with registered read.
module ffha_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

/* hdl/ffha_ctrl.sv */
// Request sequencer for the heap allocator.
module ffha_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  output logic              busy,
  input  ffha_pkg::sts_t    sts,
  output ffha_pkg::ctl_t    ctl
);
  typedef enum logic [2:0] {
    Idle, Rd, Wt, Nx, NxWt, Eval, Merge
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    ctl = '0;
    ctl.status = ffha_pkg::StOk;
    case (state_r)
      Idle: begin
        if (in_fire) begin
          ctl.load = 1'b1;
          state_nxt = Rd;
        end
      end
      Rd: begin
        if (sts.bad) begin
          ctl.finish = 1'b1;
          ctl.status = ffha_pkg::StBadReq;
          state_nxt = Idle;
        end else if (sts.cur_none || sts.out_of_steps) begin
          ctl.finish = 1'b1;
          ctl.status = sts.is_free_req ? ffha_pkg::StNotFound : ffha_pkg::StNoSpace;
          state_nxt = Idle;
        end else begin
          ctl.rd = 1'b1;
          state_nxt = Wt;
        end
      end
      // Current entry lands here.
      Wt: state_nxt = Nx;
      // Read successor of the current entry.
      Nx: begin
        ctl.rd_next = 1'b1;
        state_nxt = NxWt;
      end
      NxWt: state_nxt = Eval;
      Eval: begin
        if (sts.is_free_req && sts.addr_hit) begin
          ctl.do_mark = 1'b1;
          state_nxt = Merge;
        end else if (!sts.is_free_req && sts.fits) begin
          ctl.do_alloc = 1'b1;
          ctl.finish = 1'b1;
          state_nxt = Idle;
        end else begin
          ctl.advance = 1'b1;
          state_nxt = Rd;
        end
      end
      Merge: begin
        if (sts.next_free) begin
          ctl.do_merge = 1'b1;
          state_nxt = Nx;
        end else begin
          ctl.finish = 1'b1;
          state_nxt = Idle;
        end
      end
      default: state_nxt = Idle;
    endcase
  end

  // Hold state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= Idle;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != Idle);

`ifndef NO_ASSERTIONS
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load |-> state_r == Idle) else $error("load outside idle");
  a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({ctl.do_alloc, ctl.do_merge, ctl.do_mark, ctl.advance}))
    else $error("conflicting commands");
  a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.finish |=> state_r == Idle) else $error("finish not back to idle");
`endif
endmodule

/* hdl/ffha_dp.sv */
// Segment table, walk registers and result registers.
module ffha_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ffha_pkg::ctl_t                ctl,
  output ffha_pkg::sts_t                sts,
  input  logic                          in_req_type,
  input  logic [ffha_pkg::OffW-1:0]     in_alloc_size,
  input  logic [ffha_pkg::AddrW-1:0]    in_free_address,
  input  logic                          cfg_we,
  input  logic [0:0]                    cfg_idx,
  input  logic [ffha_pkg::AddrW-1:0]    cfg_data,
  output logic                          res_valid,
  input  logic                          res_ready,
  output logic [1:0]                    res_status,
  output logic [ffha_pkg::AddrW-1:0]    res_addr,
  output logic [ffha_pkg::OffW-1:0]     res_used,
  output logic [ffha_pkg::CountW-1:0]   res_count
);
  localparam int SW = ffha_pkg::SlotW;
  localparam int LW = ffha_pkg::LinkW;
  localparam int OW = ffha_pkg::OffW;
  localparam int HB = ffha_pkg::HeaderBytes;
  localparam int NS = ffha_pkg::MaxSegments;

  logic [ffha_pkg::AddrW-1:0] base_r;
  logic [OW-1:0] rsize_r;
  logic init_r;
  logic [SW-1:0] init_cnt_r;
  logic [NS-1:0] spare_r;
  logic [OW-1:0] used_r;
  logic [ffha_pkg::CountW-1:0] count_r;

  logic req_r;
  logic [OW-1:0] size_r;
  logic [ffha_pkg::AddrW-1:0] faddr_r;
  logic [LW-1:0] cur_r;
  logic [LW-1:0] steps_r;
  ffha_pkg::seg_t cur_seg_r;
  ffha_pkg::seg_t nx_seg_r;
  logic cur_pend_r;
  logic nx_pend_r;

  // RAM port
  logic ram_we;
  logic [SW-1:0] ram_addr;
  ffha_pkg::seg_t ram_wd, ram_rd;

  ffha_ram #(.Width(ffha_pkg::SegW), .Depth(NS)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wd), .rdata(ram_rd));

  logic [OW-1:0] rend;
  assign rend = (rsize_r < OW'(HB)) ? OW'(HB) : rsize_r;

  // Boundary of current segment, from successor read, or region end when there is none.
  logic [OW+1:0] bnd, need, need2;
  logic nx_ok;
  assign nx_ok = (cur_seg_r.link != ffha_pkg::NoLink);
  assign bnd = nx_ok ? {2'b0, nx_seg_r.start} : {2'b0, rend};
  assign need = {2'b0, cur_seg_r.start} + {2'b0, size_r} + (OW+2)'(HB);
  assign need2 = need + (OW+2)'(HB);

  // First spare slot.
  logic [SW-1:0] spare_idx;
  logic spare_any;
  always_comb begin
    spare_idx = '0;
    spare_any = 1'b0;
    for (int i = NS - 1; i >= 0; i--) begin
      if (spare_r[i]) begin
        spare_idx = SW'(i);
        spare_any = 1'b1;
      end
    end
  end

  logic split;
  assign split = (need2 < bnd) && spare_any;

  logic [ffha_pkg::AddrW-1:0] pay_addr;
  assign pay_addr = base_r + ffha_pkg::AddrW'(cur_seg_r.start) + ffha_pkg::AddrW'(HB);

  // Split writes two entries: current first, new one in the next cycle.
  logic pend_r;
  ffha_pkg::seg_t pend_seg_r;
  logic [SW-1:0] pend_idx_r;

  assign sts.bad = req_r ? (faddr_r == '0) : (size_r == '0);
  assign sts.is_free_req = req_r;
  assign sts.cur_none = (cur_r == ffha_pkg::NoLink);
  assign sts.out_of_steps = (steps_r == LW'(NS));
  assign sts.fits = cur_seg_r.free && (split || need <= bnd);
  assign sts.addr_hit = (pay_addr == faddr_r);
  assign sts.next_free = nx_ok && nx_seg_r.free;
  assign sts.init_busy = init_r || pend_r;

  // Drive RAM port.
  always_comb begin
    ram_we = 1'b0;
    ram_addr = cur_r[SW-1:0];
    ram_wd = cur_seg_r;
    if (init_r) begin
      ram_we = 1'b1;
      ram_addr = init_cnt_r;
      ram_wd = '{start: '0, size: rend - OW'(HB), free: 1'b1, link: ffha_pkg::NoLink};
    end else if (pend_r) begin
      ram_we = 1'b1;
      ram_addr = pend_idx_r;
      ram_wd = pend_seg_r;
    end else if (ctl.do_alloc) begin
      ram_we = 1'b1;
      ram_wd.free = 1'b0;
      if (split) begin
        ram_wd.size = size_r;
        ram_wd.link = {1'b0, spare_idx};
      end
    end else if (ctl.do_mark) begin
      ram_we = 1'b1;
      ram_wd.free = 1'b1;
    end else if (ctl.do_merge) begin
      ram_we = 1'b1;
      ram_wd.size = cur_seg_r.size + nx_seg_r.size + OW'(HB);
      ram_wd.link = nx_seg_r.link;
    end else if (ctl.rd_next) begin
      ram_addr = cur_seg_r.link[SW-1:0];
    end
  end

  // Sequence registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
      rsize_r <= OW'(65536);
      init_r <= 1'b1;
      init_cnt_r <= '0;
      spare_r <= {{(NS-1){1'b1}}, 1'b0};
      used_r <= '0;
      count_r <= ffha_pkg::CountW'(1);
      pend_r <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready) res_valid <= 1'b0;
      if (init_r) begin
        init_cnt_r <= init_cnt_r + SW'(1);
        if (init_cnt_r == SW'(NS - 1)) init_r <= 1'b0;
      end
      pend_r <= 1'b0;
      if (cfg_we && cfg_idx == ffha_pkg::CfgRegionBase) base_r <= cfg_data;
      if (cfg_we && cfg_idx == ffha_pkg::CfgRegionSize) begin
        rsize_r <= cfg_data[OW-1:0];
        init_r <= 1'b1;
        init_cnt_r <= '0;
        spare_r <= {{(NS-1){1'b1}}, 1'b0};
        used_r <= '0;
        count_r <= ffha_pkg::CountW'(1);
      end
      if (ctl.load) begin
        req_r <= in_req_type;
        size_r <= in_alloc_size;
        faddr_r <= in_free_address;
        cur_r <= '0;
        steps_r <= '0;
      end
      if (ctl.rd) steps_r <= steps_r + LW'(1);
      // Current entry is captured from the registered RAM read, flagged by cur_pend_r.
      if (cur_pend_r) cur_seg_r <= ram_rd;
      if (ctl.advance) cur_r <= cur_seg_r.link;
      if (ctl.do_alloc) begin
        if (split) begin
          spare_r[spare_idx] <= 1'b0;
          pend_r <= 1'b1;
          pend_idx_r <= spare_idx;
          pend_seg_r <= '{start: need[OW-1:0],
                          size: OW'(bnd - need - (OW+2)'(HB)),
                          free: 1'b1, link: cur_seg_r.link};
          used_r <= used_r + size_r + OW'(HB);
          count_r <= count_r + ffha_pkg::CountW'(1);
        end else begin
          used_r <= used_r + cur_seg_r.size + OW'(HB);
        end
      end
      if (ctl.do_mark) begin
        if (!cur_seg_r.free) used_r <= used_r - cur_seg_r.size - OW'(HB);
        cur_seg_r.free <= 1'b1;
      end
      if (ctl.do_merge) begin
        cur_seg_r.size <= cur_seg_r.size + nx_seg_r.size + OW'(HB);
        cur_seg_r.link <= nx_seg_r.link;
        spare_r[cur_seg_r.link[SW-1:0]] <= 1'b1;
        count_r <= count_r - ffha_pkg::CountW'(1);
      end
      if (ctl.finish) begin
        res_valid <= 1'b1;
        res_status <= ctl.status;
        res_addr <= (ctl.do_alloc) ? pay_addr : '0;
      end
    end
  end

  // Track which read lands next; the successor read is captured from the registered RAM read, flagged by nx_pend_r.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_pend_r <= 1'b0;
      nx_pend_r <= 1'b0;
    end else begin
      cur_pend_r <= ctl.rd;
      nx_pend_r <= ctl.rd_next;
    end
    if (nx_pend_r) nx_seg_r <= ram_rd;
  end

  assign res_used = used_r;
  assign res_count = count_r;

`ifndef NO_ASSERTIONS
  a_cnt_pos: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != '0) else $error("segment count zero");
  a_head_kept: assert property (@(posedge clk) disable iff (!rst_n)
    !spare_r[0]) else $error("head slot marked spare");
  a_pend_once: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |=> !pend_r) else $error("split write repeated");
`endif
endmodule

/* hdl/first_fit_heap_allocator.sv */
// Top level of the first-fit heap allocator.
//  channel | direction | payload
//  in_     | sink      | req_type, alloc_size, free_address
//  out_    | source    | status, payload_address, used_bytes, segment_count
//  cfg_    | write     | region_base (0), region_size (1)
// A request passes Rd, Wt, Nx, NxWt and Eval per list segment visited; each merge repeats Merge, Nx, NxWt, Eval.
// A split adds a second table write, done before the next request is taken.
// Reset, and any region_size write, clears all 64 table slots in one pass; no request meanwhile.
// A new request is taken only once the previous result has been collected.
module first_fit_heap_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  logic [23:0] in_alloc_size,
  input  logic [31:0] in_free_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [31:0] out_payload_address,
  output logic [23:0] out_used_bytes,
  output logic [6:0]  out_segment_count,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  ffha_pkg::ctl_t ctl;
  ffha_pkg::sts_t sts;
  logic busy;
  logic in_fire;

  assign in_ready = !busy && !out_valid && !sts.init_busy;
  assign in_fire = in_valid && in_ready;

  ffha_ctrl u_ctrl (.clk(clk), .rst_n(rst_n), .in_fire(in_fire), .busy(busy),
    .sts(sts), .ctl(ctl));

  ffha_dp u_dp (.clk(clk), .rst_n(rst_n), .ctl(ctl), .sts(sts),
    .in_req_type(in_req_type), .in_alloc_size(in_alloc_size),
    .in_free_address(in_free_address), .cfg_we(cfg_we), .cfg_idx(cfg_index),
    .cfg_data(cfg_data), .res_valid(out_valid), .res_ready(out_ready),
    .res_status(out_status), .res_addr(out_payload_address),
    .res_used(out_used_bytes), .res_count(out_segment_count));
endmodule

/* tb/first_fit_heap_allocator_tb.sv */
// Self-checking testbench for the first-fit heap allocator.
`timescale 1ns / 100ps

module first_fit_heap_allocator_tb;

  typedef struct packed {
    logic        req_type;
    logic [23:0] alloc_size;
    logic [31:0] free_address;
  } heap_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] payload_address;
    logic [23:0] used_bytes;
    logic [6:0]  segment_count;
  } heap_res_t;

  typedef struct {
    heap_req_t req;
    bit        typed;
    heap_res_t res;
  } dir_row_t;

  localparam logic ReqAlloc = 1'b0;
  localparam logic ReqFree  = 1'b1;
  localparam int   NSeg     = ffha_pkg::MaxSegments;
  localparam int   HdrB     = ffha_pkg::HeaderBytes;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = ffha_pkg::CfgRegionBase;
  logic [31:0] cfg_data = '0;

  ffha_if #(.T(heap_req_t)) req_ch (clk);
  ffha_if #(.T(heap_res_t)) res_ch (clk);

  // Heap shadow: segment table and registers
  logic [23:0] hp_start [NSeg];
  logic [23:0] hp_size [NSeg];
  bit          hp_free [NSeg];
  int          hp_link [NSeg];
  bit          hp_spare [NSeg];
  logic [23:0] hp_used;
  int          hp_count;
  logic [31:0] hp_base;
  logic [23:0] hp_rsize;

  heap_res_t   pending_res[$];
  logic [31:0] live_addr[$];
  dir_row_t    dir_tab[$];
  int          err_count = 0;
  int          res_count = 0;
  int          alloc_ok = 0;
  int          free_ok = 0;
  int          tx_idle_pct = 0;
  int          rx_stall_pct = 0;
  int          hold_left = 0;
  bit          hold_go = 1'b0;

  always #1 clk = ~clk;

  first_fit_heap_allocator u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (req_ch.valid),
    .in_ready            (req_ch.ready),
    .in_req_type         (req_ch.data.req_type),
    .in_alloc_size       (req_ch.data.alloc_size),
    .in_free_address     (req_ch.data.free_address),
    .out_valid           (res_ch.valid),
    .out_ready           (res_ch.ready),
    .out_status          (res_ch.data.status),
    .out_payload_address (res_ch.data.payload_address),
    .out_used_bytes      (res_ch.data.used_bytes),
    .out_segment_count   (res_ch.data.segment_count),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  function automatic int heap_end();
    return (hp_rsize < HdrB) ? HdrB : int'(hp_rsize);
  endfunction

  // Rebuild the list as one free segment
  function automatic void heap_rebuild();
    for (int i = 0; i < NSeg; i++) begin
      hp_start[i] = '0;
      hp_size[i] = '0;
      hp_free[i] = 1'b0;
      hp_link[i] = NSeg;
      hp_spare[i] = (i != 0);
    end
    hp_size[0] = 24'(heap_end() - HdrB);
    hp_free[0] = 1'b1;
    hp_used = '0;
    hp_count = 1;
  endfunction

  function automatic longint seg_boundary(int s);
    return (hp_link[s] < NSeg) ? longint'(hp_start[hp_link[s]]) : longint'(heap_end());
  endfunction

  function automatic logic [31:0] payload_at(int s);
    return hp_base + 32'(hp_start[s]) + 32'(HdrB);
  endfunction

  // First-fit walk: split when a header fits before the boundary and a slot is spare, else take whole
  function automatic ffha_pkg::status_t heap_alloc(logic [23:0] sz, output logic [31:0] addr);
    int cur;
    int n;
    longint need;
    longint bnd;
    cur = 0;
    addr = '0;
    for (int steps = 0; steps < NSeg && cur < NSeg; steps++) begin
      if (hp_free[cur]) begin
        need = longint'(hp_start[cur]) + longint'(sz) + HdrB;
        bnd = seg_boundary(cur);
        n = NSeg;
        if (need + HdrB < bnd) begin
          for (int i = NSeg - 1; i >= 0; i--)
            if (hp_spare[i]) n = i;
        end
        if (n < NSeg) begin
          hp_spare[n] = 1'b0;
          hp_start[n] = 24'(need);
          hp_size[n] = 24'(bnd - need - HdrB);
          hp_free[n] = 1'b1;
          hp_link[n] = hp_link[cur];
          hp_link[cur] = n;
          hp_size[cur] = sz;
          hp_free[cur] = 1'b0;
          hp_used = hp_used + sz + 24'(HdrB);
          hp_count++;
          addr = payload_at(cur);
          return ffha_pkg::StOk;
        end
        if (need <= bnd) begin
          hp_free[cur] = 1'b0;
          hp_used = hp_used + hp_size[cur] + 24'(HdrB);
          addr = payload_at(cur);
          return ffha_pkg::StOk;
        end
      end
      cur = hp_link[cur];
    end
    return ffha_pkg::StNoSpace;
  endfunction

  // Release a payload and merge the free run that follows it
  function automatic ffha_pkg::status_t heap_release(logic [31:0] addr);
    int cur;
    int nx;
    cur = 0;
    for (int steps = 0; steps < NSeg && cur < NSeg; steps++) begin
      if (payload_at(cur) == addr) begin
        if (!hp_free[cur]) hp_used = hp_used - hp_size[cur] - 24'(HdrB);
        hp_free[cur] = 1'b1;
        nx = hp_link[cur];
        while (nx < NSeg && hp_free[nx]) begin
          hp_size[cur] = hp_size[cur] + hp_size[nx] + 24'(HdrB);
          hp_link[cur] = hp_link[nx];
          hp_spare[nx] = 1'b1;
          hp_link[nx] = NSeg;
          hp_count--;
          nx = hp_link[cur];
        end
        return ffha_pkg::StOk;
      end
      cur = hp_link[cur];
    end
    return ffha_pkg::StNotFound;
  endfunction

  function automatic heap_res_t heap_request(heap_req_t r);
    heap_res_t o;
    ffha_pkg::status_t st;
    logic [31:0] a;
    a = '0;
    if (r.req_type == ReqAlloc)
      st = (r.alloc_size == 0) ? ffha_pkg::StBadReq : heap_alloc(r.alloc_size, a);
    else
      st = (r.free_address == 0) ? ffha_pkg::StBadReq : heap_release(r.free_address);
    if (r.req_type == ReqFree || st != ffha_pkg::StOk) a = '0;
    // Track live payloads so frees can target them
    if (st == ffha_pkg::StOk && r.req_type == ReqAlloc) begin
      live_addr.push_back(a);
      alloc_ok++;
    end
    if (st == ffha_pkg::StOk && r.req_type == ReqFree) begin
      free_ok++;
      for (int i = live_addr.size() - 1; i >= 0; i--)
        if (live_addr[i] == r.free_address) live_addr.delete(i);
    end
    o.status = st;
    o.payload_address = a;
    o.used_bytes = hp_used;
    o.segment_count = 7'(hp_count);
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp);
    $display("%0t: %s mismatch: got %0h expected %0h", $time, what, got, exp);
    err_count++;
  endtask

  // Offer one request, hold until taken, then record its expected result
  task automatic send_request(heap_req_t r, bit typed, heap_res_t typed_res);
    heap_res_t p;
    while ($urandom_range(99) < tx_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data <= r;
    do @(posedge clk); while (!req_ch.ready);
    p = heap_request(r);
    pending_res.push_back(typed ? typed_res : p);
  endtask

  task automatic stop_sending();
    req_ch.valid <= 1'b0;
  endtask

  task automatic write_reg(logic [0:0] idx, logic [31:0] val);
    while (pending_res.size() != 0) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == ffha_pkg::CfgRegionBase) begin
      hp_base = val;
    end else begin
      hp_rsize = val[23:0];
      heap_rebuild();
      live_addr.delete();
    end
  endtask

  function automatic heap_req_t random_request();
    heap_req_t r;
    int pick;
    r.req_type = ($urandom_range(99) < 55) ? ReqAlloc : ReqFree;
    r.alloc_size = 24'($urandom);
    r.free_address = $urandom;
    pick = $urandom_range(99);
    if (r.req_type == ReqAlloc) begin
      if (pick < 80) r.alloc_size = 24'($urandom_range(96, 1));
      else if (pick < 90) r.alloc_size = 24'($urandom_range(heap_end(), 1));
      else if (pick < 95) r.alloc_size = '0;
    end else begin
      if (pick < 80 && live_addr.size() != 0)
        r.free_address = live_addr[$urandom_range(live_addr.size() - 1)];
      else if (pick < 88)
        r.free_address = hp_base + 32'(HdrB);
      else if (pick < 92)
        r.free_address = '0;
    end
    return r;
  endfunction

  function automatic dir_row_t row(logic t, logic [23:0] sz, logic [31:0] fa, bit typed,
                                   ffha_pkg::status_t st, logic [31:0] pa,
                                   logic [23:0] ub, logic [6:0] sc);
    dir_row_t d;
    d.req = '{t, sz, fa};
    d.typed = typed;
    d.res = '{st, pa, ub, sc};
    return d;
  endfunction

  // Receiver: random stalls plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_go) begin
      hold_left <= 400;
      hold_go = 1'b0;
      res_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Compare each result with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && res_ch.valid && res_ch.ready) begin
      res_count++;
      if (pending_res.size() == 0) begin
        $display("%0t: result with nothing expected", $time);
        err_count++;
      end else begin
        heap_res_t e;
        e = pending_res.pop_front();
        if (res_ch.data.status != e.status)
          report_mismatch("status", 32'(res_ch.data.status), 32'(e.status));
        if (res_ch.data.payload_address != e.payload_address)
          report_mismatch("payload_address", res_ch.data.payload_address, e.payload_address);
        if (res_ch.data.used_bytes != e.used_bytes)
          report_mismatch("used_bytes", 32'(res_ch.data.used_bytes), 32'(e.used_bytes));
        if (res_ch.data.segment_count != e.segment_count)
          report_mismatch("segment_count", 32'(res_ch.data.segment_count),
                          32'(e.segment_count));
      end
    end
  end

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    int idle_tx [4];
    int idle_rx [4];
    logic [31:0] bases [4];
    logic [23:0] sizes [4];
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    hp_base = '0;
    hp_rsize = 24'd65536;
    heap_rebuild();
    idle_tx = '{0, 66, 0, 16};
    idle_rx = '{0, 0, 66, 16};
    bases = '{32'h0, 32'hFFFF_FFE8, 32'hFFFF_FFFF, 32'h1234_5678};
    sizes = '{24'd4096, 24'hFF_FFFF, 24'd24, 24'd2048};

    // Directed: bad requests, unknown address, oversize, exact fit, double free, merges
    dir_tab.push_back(row(ReqAlloc, 24'd0, 32'd0, 1, ffha_pkg::StBadReq, 32'd0, 24'd0,
                          7'd1));
    dir_tab.push_back(row(ReqFree, 24'd0, 32'd0, 1, ffha_pkg::StBadReq, 32'd0, 24'd0, 7'd1));
    dir_tab.push_back(row(ReqFree, 24'd0, 32'd5, 1, ffha_pkg::StNotFound, 32'd0, 24'd0,
                          7'd1));
    dir_tab.push_back(row(ReqAlloc, 24'hFF_FFFF, 32'hFFFF_FFFF, 1, ffha_pkg::StNoSpace,
                          32'd0, 24'd0, 7'd1));
    dir_tab.push_back(row(ReqAlloc, 24'd100, 32'd0, 1, ffha_pkg::StOk, 32'd24, 24'd124,
                          7'd2));
    dir_tab.push_back(row(ReqAlloc, 24'd65388, 32'd0, 0, ffha_pkg::StOk, 32'd0, 24'd0,
                          7'd0));
    dir_tab.push_back(row(ReqAlloc, 24'd1, 32'd0, 0, ffha_pkg::StOk, 32'd0, 24'd0, 7'd0));
    dir_tab.push_back(row(ReqFree, 24'hFF_FFFF, 32'd24, 0, ffha_pkg::StOk, 32'd0, 24'd0,
                          7'd0));
    dir_tab.push_back(row(ReqFree, 24'd0, 32'd24, 0, ffha_pkg::StOk, 32'd0, 24'd0, 7'd0));
    dir_tab.push_back(row(ReqFree, 24'd0, 32'd148, 0, ffha_pkg::StOk, 32'd0, 24'd0, 7'd0));
    dir_tab.push_back(row(ReqFree, 24'd0, 32'd24, 0, ffha_pkg::StOk, 32'd0, 24'd0, 7'd0));
    dir_tab.push_back(row(ReqAlloc, 24'd1, 32'd0, 0, ffha_pkg::StOk, 32'd0, 24'd0, 7'd0));
    dir_tab.push_back(row(ReqAlloc, 24'd1, 32'd0, 0, ffha_pkg::StOk, 32'd0, 24'd0, 7'd0));
    dir_tab.push_back(row(ReqAlloc, 24'd1, 32'd0, 0, ffha_pkg::StOk, 32'd0, 24'd0, 7'd0));
    dir_tab.push_back(row(ReqFree, 24'd0, 32'd49, 0, ffha_pkg::StOk, 32'd0, 24'd0, 7'd0));
    dir_tab.push_back(row(ReqFree, 24'd0, 32'd24, 0, ffha_pkg::StOk, 32'd0, 24'd0, 7'd0));
    dir_tab.push_back(row(ReqFree, 24'd0, 32'hFFFF_FFFF, 0, ffha_pkg::StOk, 32'd0, 24'd0,
                          7'd0));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) send_request(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].res);
    stop_sending();

    // Payload wrapping onto address zero cannot be released
    write_reg(ffha_pkg::CfgRegionBase, 32'hFFFF_FFE8);
    send_request('{ReqAlloc, 24'd8, 32'd0}, 0, '0);
    send_request('{ReqFree, 24'd0, 32'd0}, 0, '0);
    stop_sending();

    // Random phases over idling modes and region settings
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(ffha_pkg::CfgRegionBase, bases[ph % 4]);
      write_reg(ffha_pkg::CfgRegionSize, 32'(sizes[(ph + ph / 4) % 4]));
      tx_idle_pct = idle_tx[ph % 4];
      rx_stall_pct = idle_rx[ph % 4];
      for (int n = 0; n < 185; n++) begin
        if (ph == 4 && n == 20) hold_go = 1'b1;
        send_request(random_request(), 0, '0);
      end
      stop_sending();
    end

    while (pending_res.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    $display("Checked %0d results: %0d allocations and %0d releases succeeded,",
             res_count, alloc_ok, free_ok);
    $display("over 8 region settings, four idling modes and one long output hold-off.");
    if (err_count == 0 && pending_res.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
